[hw/rtl/assert_macros.svh]
// assertion helpers included by the connectivity core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/ufc_pkg.sv]
`default_nettype none

package ufc_pkg;

    localparam int NODE_W    = 10;
    localparam int MAX_NODES = 2 ** NODE_W;
    localparam int CNT_W     = 32;

    localparam logic [1:0] FUNC_CONNECT = 2'd0;
    localparam logic [1:0] FUNC_QUERY   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(1022);

    typedef struct packed {
        logic [1:0]        func;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_beat;

    typedef struct packed {
        logic             connected;
        logic [CNT_W-1:0] success_count;
        logic [CNT_W-1:0] failure_count;
        logic             index_error;
    } t_out_beat;

endpackage

`default_nettype wire

[hw/rtl/ufc_ram.sv]
`default_nettype none

// simple dual-port ram, one write and one registered read per cycle
module ufc_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hw/rtl/union_find_connectivity_core.sv]
// channel   direction  handshake                 payload
// --------  ---------  ------------------------  ------------------------------
// in        sink       i_in_valid / o_in_stall   i_in_data  (ufc_pkg::t_in_beat)
// out       source     o_out_valid / i_out_stall o_out_data (ufc_pkg::t_out_beat)
// cfg       sink       i_cfg_we                  i_cfg_data (node_count)
//
// find: a connect or query follows the parent hops from node a to its root, then from
//   node b to its root; the parent ram read port walks one hop per cycle
// a clear rewrites each entry from zero through node_count + 1 with its own index, capped at the table end
// an item with a bad index or an unused func skips the ram and goes straight to the done state
// reset: after i_rst_n releases, a sweep loads each of the 1024 parent entries with
//   its own index; o_in_stall stays high through it, cfg writes are taken as ever
// stalls: a finished beat sits in the output register; the next beat is accepted and
//   worked on while it waits, and only the final hand-off waits for the slot to free up
`default_nettype none

`include "assert_macros.svh"

module union_find_connectivity_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire ufc_pkg::t_in_beat              i_in_data,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output ufc_pkg::t_out_beat                  o_out_data,
    // node_count register
    input  wire logic                           i_cfg_we,
    input  wire logic [ufc_pkg::NODE_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_FIND_A,
        S_FIND_B,
        S_CLEAR,
        S_DONE
    } t_state;

    localparam logic [ufc_pkg::NODE_W-1:0] LAST_NODE = ufc_pkg::NODE_W'(ufc_pkg::MAX_NODES - 1);

    // control and item registers
    t_state                         r_state, n_state;
    logic [ufc_pkg::NODE_W-1:0]     r_node_count, n_node_count;
    logic [1:0]                     r_func, n_func;
    logic [ufc_pkg::NODE_W-1:0]     r_node_b, n_node_b;
    logic                           r_err, n_err;
    logic                           r_connected, n_connected;
    // find walk
    logic [ufc_pkg::NODE_W-1:0]     r_cur, n_cur;
    logic [ufc_pkg::NODE_W-1:0]     r_prev, n_prev;
    logic                           r_prev_ok, n_prev_ok;
    logic [ufc_pkg::NODE_W-1:0]     r_root_a, n_root_a;
    // sweep for reset and clear
    logic [ufc_pkg::NODE_W-1:0]     r_sweep, n_sweep;
    logic [ufc_pkg::NODE_W-1:0]     r_sweep_last, n_sweep_last;
    // running counts
    logic [ufc_pkg::CNT_W-1:0]      r_succ, n_succ;
    logic [ufc_pkg::CNT_W-1:0]      r_fail, n_fail;
    // output register
    logic                           r_out_valid, n_out_valid;
    ufc_pkg::t_out_beat             r_out_data, n_out_data;

    // ram ports
    logic                           w_rd_en;
    logic [ufc_pkg::NODE_W-1:0]     w_rd_addr;
    logic [ufc_pkg::NODE_W-1:0]     w_rd_data;
    logic                           w_wr_en;
    logic [ufc_pkg::NODE_W-1:0]     w_wr_addr;
    logic [ufc_pkg::NODE_W-1:0]     w_wr_data;

    logic                           w_a_ok;
    logic                           w_b_ok;
    logic [ufc_pkg::NODE_W:0]       w_nc_inc;
    logic [ufc_pkg::NODE_W-1:0]     w_clear_last;
    logic                           w_at_root;
    logic                           w_done_fire;
    logic                           w_clear_fire;

    ufc_ram #(
        .DEPTH (ufc_pkg::MAX_NODES),
        .WIDTH (ufc_pkg::NODE_W)
    ) u_parent (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // index range check against the configured node count
    assign w_a_ok = (i_in_data.node_a <= r_node_count);
    assign w_b_ok = (i_in_data.node_b <= r_node_count);

    // clear covers entries zero through node_count + 1, stopping at the table end
    assign w_nc_inc     = {1'b0, r_node_count} + (ufc_pkg::NODE_W + 1)'(1);
    assign w_clear_last = w_nc_inc[ufc_pkg::NODE_W] ? LAST_NODE
                                                    : w_nc_inc[ufc_pkg::NODE_W-1:0];

    // parent read of r_cur came back pointing at itself
    assign w_at_root = (w_rd_data == r_cur);

    assign w_done_fire  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_clear_fire = w_done_fire && (r_func == ufc_pkg::FUNC_CLEAR);

    always_comb begin
        n_state      = r_state;
        n_node_count = r_node_count;
        n_func       = r_func;
        n_node_b     = r_node_b;
        n_err        = r_err;
        n_connected  = r_connected;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_prev_ok    = r_prev_ok;
        n_root_a     = r_root_a;
        n_sweep      = r_sweep;
        n_sweep_last = r_sweep_last;
        n_succ       = r_succ;
        n_fail       = r_fail;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        w_rd_en   = 1'b0;
        w_rd_addr = r_cur;
        w_wr_en   = 1'b0;
        w_wr_addr = r_prev;
        w_wr_data = w_rd_data;

        // downstream took the held beat
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_node_count = i_cfg_data;
        end

        case (r_state)
            S_INIT: begin
                // load every entry with its own index
                w_wr_en   = 1'b1;
                w_wr_addr = r_sweep;
                w_wr_data = r_sweep;
                if (r_sweep == LAST_NODE) begin
                    n_state = S_IDLE;
                end else begin
                    n_sweep = r_sweep + ufc_pkg::NODE_W'(1);
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_func      = i_in_data.func;
                    n_node_b    = i_in_data.node_b;
                    n_err       = 1'b0;
                    n_connected = 1'b0;
                    case (i_in_data.func)
                        ufc_pkg::FUNC_CONNECT, ufc_pkg::FUNC_QUERY: begin
                            if (w_a_ok && w_b_ok) begin
                                // start the walk from node a
                                w_rd_en   = 1'b1;
                                w_rd_addr = i_in_data.node_a;
                                n_cur     = i_in_data.node_a;
                                n_prev_ok = 1'b0;
                                n_state   = S_FIND_A;
                            end else begin
                                n_err   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        ufc_pkg::FUNC_CLEAR: begin
                            n_sweep      = '0;
                            n_sweep_last = w_clear_last;
                            n_state      = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_FIND_A, S_FIND_B: begin
                if (w_at_root) begin
                    if (r_state == S_FIND_A) begin
                        // root of a found, restart the walk from node b
                        n_root_a  = r_cur;
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_node_b;
                        n_cur     = r_node_b;
                        n_prev_ok = 1'b0;
                        n_state   = S_FIND_B;
                    end else begin
                        if (r_func == ufc_pkg::FUNC_CONNECT) begin
                            // hang root of a under root of b
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_root_a;
                            w_wr_data = r_cur;
                        end
                        n_connected = (r_func == ufc_pkg::FUNC_QUERY) && (r_root_a == r_cur);
                        n_state     = S_DONE;
                    end
                end else begin
                    // path splitting: the node behind us now points at its grandparent
                    w_wr_en   = r_prev_ok;
                    w_wr_addr = r_prev;
                    w_wr_data = w_rd_data;
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_rd_data;
                    n_prev    = r_cur;
                    n_prev_ok = 1'b1;
                    n_cur     = w_rd_data;
                end
            end

            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_sweep;
                w_wr_data = r_sweep;
                if (r_sweep == r_sweep_last) begin
                    n_state = S_DONE;
                end else begin
                    n_sweep = r_sweep + ufc_pkg::NODE_W'(1);
                end
            end

            S_DONE: begin
                if (w_done_fire) begin
                    if (r_func == ufc_pkg::FUNC_CLEAR) begin
                        n_succ = '0;
                        n_fail = '0;
                    end else if (r_func == ufc_pkg::FUNC_QUERY && !r_err) begin
                        // saturating counts
                        if (r_connected) begin
                            if (r_succ != '1) begin
                                n_succ = r_succ + ufc_pkg::CNT_W'(1);
                            end
                        end else begin
                            if (r_fail != '1) begin
                                n_fail = r_fail + ufc_pkg::CNT_W'(1);
                            end
                        end
                    end
                    n_out_valid              = 1'b1;
                    n_out_data.connected     = r_connected;
                    n_out_data.success_count = n_succ;
                    n_out_data.failure_count = n_fail;
                    n_out_data.index_error   = r_err;
                    n_state                  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_node_count <= ufc_pkg::NODE_COUNT_RST;
            r_sweep      <= '0;
            r_prev_ok    <= 1'b0;
            r_succ       <= '0;
            r_fail       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_sweep      <= n_sweep;
            r_prev_ok    <= n_prev_ok;
            r_succ       <= n_succ;
            r_fail       <= n_fail;
            r_out_valid  <= n_out_valid;
        end
        r_func       <= n_func;
        r_node_b     <= n_node_b;
        r_err        <= n_err;
        r_connected  <= n_connected;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_root_a     <= n_root_a;
        r_sweep_last <= n_sweep_last;
        r_out_data   <= n_out_data;
    end

    // only the idle state takes a beat
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ram writes only come from the sweeps and the find walk
    `ASSERT_ALWAYS(a_wr_state, i_clk, i_rst_n, !w_wr_en || (r_state != S_IDLE && r_state != S_DONE))

    // a fresh output beat is always the hand-off of a finished item
    `ASSERT_ALWAYS(a_out_from_done, i_clk, i_rst_n, !$rose(o_out_valid) || $past(r_state == S_DONE))

    // counts never move down except through a clear
    `ASSERT_ALWAYS(a_succ_mono, i_clk, i_rst_n, !($past(i_rst_n) && !$past(w_clear_fire)) || (r_succ >= $past(r_succ)))
    `ASSERT_ALWAYS(a_fail_mono, i_clk, i_rst_n, !($past(i_rst_n) && !$past(w_clear_fire)) || (r_fail >= $past(r_fail)))

    // an item flagged for a bad index never reports a connection
    `ASSERT_ALWAYS(a_err_excl, i_clk, i_rst_n, !o_out_valid || !(o_out_data.connected && o_out_data.index_error))

endmodule

`default_nettype wire

[tb/sv/union_find_connectivity_core_test.sv]
`timescale 1ns / 1ps

module union_find_connectivity_core_test;

    // short local names for the func codes used in the stimulus table
    localparam logic [1:0] OP_CONNECT = ufc_pkg::FUNC_CONNECT;
    localparam logic [1:0] OP_QUERY   = ufc_pkg::FUNC_QUERY;
    localparam logic [1:0] OP_CLEAR   = ufc_pkg::FUNC_CLEAR;
    // func code that the block must ignore
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // cycles with no beat moving on either channel before the run is called dead
    // (covers the reset sweep, a full clear and two deep finds with room to spare)
    localparam int QUIET_LIMIT = 20000;
    // long receiver hold-off, enough to back the block up into its input
    localparam int HOLD_CYCLES = 400;
    // settle time after the last result
    localparam int END_CYCLES  = 20;

    // one directed beat, with a hand-typed result where it is obvious
    typedef struct packed {
        ufc_pkg::t_in_beat  beat;
        bit                 has_exp;
        ufc_pkg::t_out_beat exp;
    } t_script_row;

    // one random phase: register setting, idling and pressure points
    typedef struct packed {
        int nc;
        int gap_pct;
        int stall_pct;
        int items;
        int hold_at;
        int pause_at;
    } t_phase;

    typedef struct packed {
        bit                 has_exp;
        ufc_pkg::t_out_beat exp;
    } t_given;

    localparam ufc_pkg::t_out_beat FROM_MODEL = '0;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    ufc_pkg::t_in_beat          in_beat   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    ufc_pkg::t_out_beat         out_beat;
    logic                       cfg_we    = 1'b0;
    logic [ufc_pkg::NODE_W-1:0] cfg_data  = '0;

    union_find_connectivity_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // shadow disjoint-set state, advanced once per accepted input beat
    // ------------------------------------------------------------------
    logic [ufc_pkg::NODE_W-1:0] parents [ufc_pkg::MAX_NODES];
    logic [ufc_pkg::CNT_W-1:0]  hits;
    logic [ufc_pkg::CNT_W-1:0]  misses;
    logic [ufc_pkg::NODE_W-1:0] model_nc;

    // root lookup with path halving, same answers as any other compression
    function automatic int root_of(input logic [ufc_pkg::NODE_W-1:0] node);
        int x;
        int steps;
        x = node;
        steps = 0;
        while (parents[x] != x && steps < ufc_pkg::MAX_NODES) begin
            parents[x] = parents[parents[x]];
            x = parents[x];
            steps++;
        end
        return x;
    endfunction

    function automatic ufc_pkg::t_out_beat predict_beat(input ufc_pkg::t_in_beat b);
        ufc_pkg::t_out_beat r;
        int ra;
        int rb;
        int last;
        int i;
        r = '0;
        case (b.func)
            OP_CLEAR: begin
                // clear reaches one entry past node_count, capped at the table end
                last = int'(model_nc) + 1;
                if (last > ufc_pkg::MAX_NODES - 1)
                    last = ufc_pkg::MAX_NODES - 1;
                for (i = 0; i <= last; i++)
                    parents[i] = ufc_pkg::NODE_W'(i);
                hits = '0;
                misses = '0;
            end
            OP_CONNECT, OP_QUERY: begin
                if (b.node_a > model_nc || b.node_b > model_nc) begin
                    // bad index: nothing moves, only the flag is raised
                    r.index_error = 1'b1;
                end else begin
                    ra = root_of(b.node_a);
                    rb = root_of(b.node_b);
                    if (b.func == OP_CONNECT) begin
                        parents[ra] = ufc_pkg::NODE_W'(rb);
                    end else if (ra == rb) begin
                        r.connected = 1'b1;
                        if (hits != '1)
                            hits++;
                    end else if (misses != '1) begin
                        misses++;
                    end
                end
            end
            default: ;
        endcase
        r.success_count = hits;
        r.failure_count = misses;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard
    // ------------------------------------------------------------------
    t_given             given_q[$];
    ufc_pkg::t_out_beat expected_q[$];
    int                 errors;
    int                 n_beats;
    int                 n_connect;
    int                 n_query;
    int                 n_clear;
    int                 n_bad;
    int                 n_results;

    task automatic check_field(input string name, input logic [ufc_pkg::CNT_W-1:0] want,
                               input logic [ufc_pkg::CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // samples both channels at the rising edge; inputs only move on the falling one
    always @(posedge clk) begin : beat_monitor
        t_given             g;
        ufc_pkg::t_out_beat pred;
        ufc_pkg::t_out_beat want;
        if (rst_n) begin
            if (cfg_we)
                model_nc = cfg_data;
            if (in_valid && !in_stall) begin
                g = given_q.pop_front();
                pred = predict_beat(in_beat);
                // a typed-in result stands in for the shadow model on directed rows
                expected_q = {expected_q, (g.has_exp ? g.exp : pred)};
                n_beats++;
                if (in_beat.func == OP_CONNECT)
                    n_connect++;
                if (in_beat.func == OP_QUERY)
                    n_query++;
                if (in_beat.func == OP_CLEAR)
                    n_clear++;
                if (pred.index_error)
                    n_bad++;
            end
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %p",
                             $time, out_beat);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("connected", ufc_pkg::CNT_W'(want.connected),
                                ufc_pkg::CNT_W'(out_beat.connected));
                    check_field("success_count", want.success_count,
                                out_beat.success_count);
                    check_field("failure_count", want.failure_count,
                                out_beat.failure_count);
                    check_field("index_error", ufc_pkg::CNT_W'(want.index_error),
                                ufc_pkg::CNT_W'(out_beat.index_error));
                    n_results++;
                end
            end
        end
    end

    // watchdog: nothing moving for too long means a hang
    int quiet_cycles;
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("union_find_connectivity_core verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, plus a long hold-off on request
    // ------------------------------------------------------------------
    int stall_pct;
    int holds_asked;
    int holds_served;
    int hold_left;

    always @(negedge clk) begin
        if (hold_left == 0 && holds_asked != holds_served) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    int gap_pct;
    int cur_nc;

    // offer one beat, with random idle cycles ahead of it, and hold it until taken
    task automatic send_beat(input ufc_pkg::t_in_beat b, input bit has_exp,
                             input ufc_pkg::t_out_beat exp);
        t_given g;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        g.has_exp = has_exp;
        g.exp = exp;
        given_q = {given_q, g};
        in_valid <= 1'b1;
        in_beat <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_node_count(input int nc);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= ufc_pkg::NODE_W'(nc);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_nc = nc;
    endtask

    // mostly well-formed connects and queries inside node_count, with some
    // out-of-range indices, unused func codes and the odd clear mixed in
    function automatic ufc_pkg::t_in_beat random_beat();
        ufc_pkg::t_in_beat b;
        int r;
        int bad;
        r = $urandom_range(99);
        b.func = ($urandom_range(99) < 45) ? OP_CONNECT : OP_QUERY;
        b.node_a = ufc_pkg::NODE_W'($urandom_range(cur_nc));
        b.node_b = ufc_pkg::NODE_W'($urandom_range(cur_nc));
        if (r < 3) begin
            b.func = OP_CLEAR;
            b.node_a = ufc_pkg::NODE_W'($urandom);
            b.node_b = ufc_pkg::NODE_W'($urandom);
        end else if (r < 6) begin
            b.func = OP_UNUSED;
            b.node_a = ufc_pkg::NODE_W'($urandom);
            b.node_b = ufc_pkg::NODE_W'($urandom);
        end else if (r < 14) begin
            bad = $urandom_range(ufc_pkg::MAX_NODES - 1, cur_nc + 1);
            if ($urandom_range(1))
                b.node_a = ufc_pkg::NODE_W'(bad);
            else
                b.node_b = ufc_pkg::NODE_W'(bad);
        end
        return b;
    endfunction

    t_script_row script [20];
    t_phase      plan [8];

    initial begin : main
        int i;
        int k;
        for (i = 0; i < ufc_pkg::MAX_NODES; i++)
            parents[i] = ufc_pkg::NODE_W'(i);
        hits = '0;
        misses = '0;
        model_nc = ufc_pkg::NODE_COUNT_RST;
        cur_nc = ufc_pkg::NODE_COUNT_RST;
        gap_pct = 0;
        stall_pct = 0;

        // directed rows, run at the reset node_count of 1022
        script = '{
            // same node is always connected
            '{'{OP_QUERY,   10'd0,    10'd0},    1'b1, '{1'b1, 32'd1, 32'd0, 1'b0}},
            // 1023 is past node_count: flagged and ignored
            '{'{OP_QUERY,   10'd0,    10'd1023}, 1'b1, '{1'b0, 32'd1, 32'd0, 1'b1}},
            '{'{OP_QUERY,   10'd1023, 10'd0},    1'b1, '{1'b0, 32'd1, 32'd0, 1'b1}},
            '{'{OP_CONNECT, 10'd1023, 10'd1023}, 1'b1, '{1'b0, 32'd1, 32'd0, 1'b1}},
            '{'{OP_QUERY,   10'd0,    10'd1},    1'b1, '{1'b0, 32'd1, 32'd1, 1'b0}},
            '{'{OP_CONNECT, 10'd0,    10'd1},    1'b1, '{1'b0, 32'd1, 32'd1, 1'b0}},
            '{'{OP_QUERY,   10'd1,    10'd0},    1'b1, '{1'b1, 32'd2, 32'd1, 1'b0}},
            // unused func: nothing moves, no flag
            '{'{OP_UNUSED,  10'd1023, 10'd1023}, 1'b1, '{1'b0, 32'd2, 32'd1, 1'b0}},
            // short chains through the top index
            '{'{OP_CONNECT, 10'd1022, 10'd0},    1'b0, FROM_MODEL},
            '{'{OP_QUERY,   10'd1022, 10'd1},    1'b0, FROM_MODEL},
            '{'{OP_CONNECT, 10'd2,    10'd3},    1'b0, FROM_MODEL},
            '{'{OP_CONNECT, 10'd3,    10'd4},    1'b0, FROM_MODEL},
            '{'{OP_CONNECT, 10'd4,    10'd1022}, 1'b0, FROM_MODEL},
            '{'{OP_QUERY,   10'd2,    10'd0},    1'b0, FROM_MODEL},
            '{'{OP_QUERY,   10'd5,    10'd1022}, 1'b0, FROM_MODEL},
            // clear ignores its node fields and zeroes both counts
            '{'{OP_CLEAR,   10'd1023, 10'd1023}, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0}},
            '{'{OP_QUERY,   10'd1,    10'd0},    1'b1, '{1'b0, 32'd0, 32'd1, 1'b0}},
            '{'{OP_QUERY,   10'd1022, 10'd1022}, 1'b1, '{1'b1, 32'd1, 32'd1, 1'b0}},
            '{'{OP_CONNECT, 10'd1022, 10'd1021}, 1'b0, FROM_MODEL},
            '{'{OP_QUERY,   10'd1021, 10'd1022}, 1'b0, FROM_MODEL}
        };

        // node_count, sender idle %, receiver stall %, beats, hold-off at, pause at
        plan = '{
            '{7,    0,  0,  200, -1, -1},
            '{1,    64, 0,  100, -1, -1},
            '{31,   0,  64, 200, -1, -1},
            '{1022, 33, 33, 150, -1, -1},
            '{63,   0,  0,  200, 60, -1},
            '{15,   64, 0,  150, -1, 75},
            '{511,  0,  64, 130, -1, -1},
            '{3,    33, 33, 200, -1, -1}
        };

        // synchronous reset held low from the start, released on a falling edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // the block stalls its input through the post-reset sweep
        foreach (script[s])
            send_beat(script[s].beat, script[s].has_exp, script[s].exp);

        foreach (plan[p]) begin
            // register only changes with the block idle
            drain();
            write_node_count(plan[p].nc);
            gap_pct = plan[p].gap_pct;
            stall_pct = plan[p].stall_pct;
            for (k = 0; k < plan[p].items; k++) begin
                // receiver backs off while the sender keeps offering
                if (k == plan[p].hold_at)
                    holds_asked++;
                // sender stops until every result is home
                if (k == plan[p].pause_at)
                    drain();
                send_beat(random_beat(), 1'b0, FROM_MODEL);
            end
        end

        drain();
        repeat (END_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d connects, %0d queries, %0d clears, %0d bad index",
                 n_beats, n_connect, n_query, n_clear, n_bad);
        $display("node_count settings 1 to 1022 across %0d phases, %0d results checked",
                 $size(plan), n_results);
        if (errors == 0)
            $display("union_find_connectivity_core verification clean");
        else
            $display("union_find_connectivity_core verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ufc_pkg.sv
hw/rtl/ufc_ram.sv
hw/rtl/union_find_connectivity_core.sv
tb/sv/union_find_connectivity_core_test.sv
